// ----- rtl/core/pds_pkg.sv -----
// Shared constants and types for the pairwise distance sorter.
// No dependencies; imported by pds_dist and pairwise_distance_sorter.
`default_nettype none

package pds_pkg;

  localparam int MAX_POINTS = 8;
  localparam int COORD_BITS = 16;

  localparam int MAX_PAIRS  = (MAX_POINTS * (MAX_POINTS - 1)) / 2;
  localparam int DIST_BITS  = 2 * COORD_BITS + 2;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int PT_IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int PAIR_IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PAIR_CNT_W = $clog2(MAX_PAIRS + 1);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } point_t;

  // One slot of the sorted pair list: endpoint indexes and squared distance.
  typedef struct packed {
    logic [PT_IDX_W-1:0]  ia;
    logic [PT_IDX_W-1:0]  ib;
    logic [DIST_BITS-1:0] dsq;
  } pair_t;

endpackage

`default_nettype wire

// ----- rtl/core/pds_dist.sv -----
// Squared distance unit: one shared multiplier, three squares summed.
// Depends on pds_pkg.
`default_nettype none

module pds_dist (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  pds_pkg::point_t                 pa,
  input  pds_pkg::point_t                 pb,
  output logic                            done,
  output logic [pds_pkg::DIST_BITS-1:0]   dsq
);
  import pds_pkg::*;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_SQ0,
    DS_SQ1,
    DS_SQ2,
    DS_SUM
  } dstate_t;

  dstate_t               state;
  logic [COORD_BITS-1:0] mx;
  logic [COORD_BITS-1:0] my;
  logic [COORD_BITS-1:0] mz;
  logic [SQ_BITS-1:0]    prod;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] nd;
    d  = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    nd = -d;
    return d[COORD_BITS] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        DS_IDLE: begin
          if (go) begin
            mx    <= abs_diff(pa.x, pb.x);
            my    <= abs_diff(pa.y, pb.y);
            mz    <= abs_diff(pa.z, pb.z);
            state <= DS_SQ0;
          end
        end
        DS_SQ0: begin
          prod  <= mx * mx;
          state <= DS_SQ1;
        end
        DS_SQ1: begin
          prod  <= my * my;
          dsq   <= DIST_BITS'(prod);
          state <= DS_SQ2;
        end
        DS_SQ2: begin
          prod  <= mz * mz;
          dsq   <= dsq + DIST_BITS'(prod);
          state <= DS_SUM;
        end
        DS_SUM: begin
          dsq   <= dsq + DIST_BITS'(prod);
          done  <= 1'b1;
          state <= DS_IDLE;
        end
        default: state <= DS_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pairwise_distance_sorter.sv -----
// Top level of the pairwise distance sorter: point memory, pair memory, sequencer.
// Depends on pds_pkg and pds_dist.
//
// Points load one per cycle while busy is low; extra points beyond the point
// memory depth are dropped. The point marked batch_end starts the batch work
// and busy stays high until the last result has been issued. For every pair
// the block reads both points, forms the squared distance in the shared
// multiplier and insertion-sorts it into the pair memory, moving past one
// entry at a time, since the single read port of that memory serves one
// compare at a time. Results are then issued in turn, each after a pair
// read and two point reads. Each result is shown for a single cycle with
// valid high and the receiver cannot stall it; last_pair marks the final
// one. A batch of one point issues nothing.
`default_nettype none

module pairwise_distance_sorter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [pds_pkg::COORD_BITS-1:0] px,
  input  logic signed [pds_pkg::COORD_BITS-1:0] py,
  input  logic signed [pds_pkg::COORD_BITS-1:0] pz,
  input  logic                                  batch_end,
  output logic                                  valid,
  output logic signed [pds_pkg::COORD_BITS-1:0] ax,
  output logic signed [pds_pkg::COORD_BITS-1:0] ay,
  output logic signed [pds_pkg::COORD_BITS-1:0] az,
  output logic signed [pds_pkg::COORD_BITS-1:0] bx,
  output logic signed [pds_pkg::COORD_BITS-1:0] by,
  output logic signed [pds_pkg::COORD_BITS-1:0] bz,
  output logic        [pds_pkg::DIST_BITS-1:0]  dist_sq,
  output logic                                  last_pair
);
  import pds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_DIST_GO,
    S_DIST_WAIT,
    S_INS_RD,
    S_INS_CMP,
    S_OUT_RP,
    S_OUT_RA,
    S_OUT_RB,
    S_OUT_EM
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [CNT_W-1:0]       npts;
  logic [PT_IDX_W-1:0]    pi;
  logic [PT_IDX_W-1:0]    pj;
  logic [PAIR_CNT_W-1:0]  npairs;
  logic [PAIR_CNT_W-1:0]  k;
  logic [DIST_BITS-1:0]   key;
  point_t                 pa;
  logic                   accept;

  // Point memory
  point_t                 pt_mem [MAX_POINTS];
  point_t                 pt_rdata;
  logic [PT_IDX_W-1:0]    pt_raddr;
  logic                   pt_wen;

  // Pair memory
  pair_t                  pr_mem [MAX_PAIRS];
  pair_t                  pr_rdata;
  logic [PAIR_IDX_W-1:0]  pr_raddr;
  logic                   pr_ren;
  logic                   pr_wen;
  logic [PAIR_IDX_W-1:0]  pr_waddr;
  pair_t                  pr_wdata;
  pair_t                  new_pair;

  logic                   dist_go;
  logic                   dist_done;
  logic [DIST_BITS-1:0]   dist_val;
  logic                   ins_done;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pt_wen = accept && (count < CNT_W'(MAX_POINTS));
  assign count_next = pt_wen ? count + CNT_W'(1) : count;
  assign dist_go = (state == S_DIST_GO);
  assign new_pair = '{ia: pi, ib: pj, dsq: key};

  pds_dist u_dist (
    .clk  (clk),
    .rst  (rst),
    .go   (dist_go),
    .pa   (pa),
    .pb   (pt_rdata),
    .done (dist_done),
    .dsq  (dist_val)
  );

  always_ff @(posedge clk) begin
    if (pt_wen) begin
      pt_mem[count[PT_IDX_W-1:0]] <= '{x: px, y: py, z: pz};
    end
    pt_rdata <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (pr_wen) begin
      pr_mem[pr_waddr] <= pr_wdata;
    end
    if (pr_ren) begin
      pr_rdata <= pr_mem[pr_raddr];
    end
  end

  // Memory port control
  always_comb begin
    pt_raddr = pi;
    pr_raddr = k[PAIR_IDX_W-1:0];
    pr_ren   = 1'b0;
    pr_wen   = 1'b0;
    pr_waddr = k[PAIR_IDX_W-1:0];
    pr_wdata = new_pair;
    ins_done = 1'b0;
    case (state)
      S_RD_B:   pt_raddr = pj;
      S_OUT_RA: pt_raddr = pr_rdata.ia;
      S_OUT_RB: pt_raddr = pr_rdata.ib;
      S_INS_RD: begin
        if (k == '0) begin
          pr_wen   = 1'b1;
          ins_done = 1'b1;
        end else begin
          pr_ren   = 1'b1;
          pr_raddr = PAIR_IDX_W'(k - PAIR_CNT_W'(1));
        end
      end
      S_INS_CMP: begin
        pr_wen = 1'b1;
        if (pr_rdata.dsq < key) begin
          // shift the smaller entry down one slot
          pr_wdata = pr_rdata;
        end else begin
          ins_done = 1'b1;
        end
      end
      S_OUT_RP: pr_ren = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      valid  <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (batch_end) begin
              count  <= '0;
              npts   <= count_next;
              pi     <= '0;
              pj     <= PT_IDX_W'(1);
              npairs <= '0;
              if (count_next >= CNT_W'(2)) begin
                state <= S_RD_A;
              end
            end else begin
              count <= count_next;
            end
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          pa    <= pt_rdata;
          state <= S_DIST_GO;
        end
        S_DIST_GO: state <= S_DIST_WAIT;
        S_DIST_WAIT: begin
          if (dist_done) begin
            key   <= dist_val;
            k     <= npairs;
            state <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          if (!ins_done) begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (!ins_done) begin
            k     <= k - PAIR_CNT_W'(1);
            state <= S_INS_RD;
          end
        end
        S_OUT_RP: state <= S_OUT_RA;
        S_OUT_RA: state <= S_OUT_RB;
        S_OUT_RB: begin
          pa    <= pt_rdata;
          state <= S_OUT_EM;
        end
        S_OUT_EM: begin
          valid     <= 1'b1;
          ax        <= pa.x;
          ay        <= pa.y;
          az        <= pa.z;
          bx        <= pt_rdata.x;
          by        <= pt_rdata.y;
          bz        <= pt_rdata.z;
          dist_sq   <= pr_rdata.dsq;
          last_pair <= (k + PAIR_CNT_W'(1) == npairs);
          k         <= k + PAIR_CNT_W'(1);
          if (k + PAIR_CNT_W'(1) == npairs) begin
            state <= S_IDLE;
          end else begin
            state <= S_OUT_RP;
          end
        end
        default: state <= S_IDLE;
      endcase

      // advance to the next pair once the insert lands
      if ((state == S_INS_RD || state == S_INS_CMP) && ins_done) begin
        npairs <= npairs + PAIR_CNT_W'(1);
        if (CNT_W'(pj) + CNT_W'(1) < npts) begin
          pj    <= pj + PT_IDX_W'(1);
          state <= S_RD_A;
        end else if (CNT_W'(pi) + CNT_W'(2) < npts) begin
          pi    <= pi + PT_IDX_W'(1);
          pj    <= PT_IDX_W'(CNT_W'(pi) + CNT_W'(2));
          state <= S_RD_A;
        end else begin
          k     <= '0;
          state <= S_OUT_RP;
        end
      end
    end
  end

endmodule

`default_nettype wire
